// ===== design/tpd_pkg.sv =====
// Package: types and constants for the triac phase dimmer and switch controller
`default_nettype none
package tpd_pkg;

  localparam int DELAY_W  = 8;
  localparam int PHASE_W  = 9;
  localparam int STEP_W   = 8;
  localparam int PULSE_W  = 4;
  localparam int LEVELS_W = 6;
  localparam int LOADS_W  = 3;
  localparam int CHAR_W   = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int SVAL_W   = 13;

  localparam logic [STEP_W-1:0]  DIM_STEP_RST   = 8'd10;
  localparam logic [PULSE_W-1:0] GATE_PULSE_RST = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_PULSE = 8'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_B    = 8'h42;
  localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_E    = 8'h45;
  localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_S    = 8'h53;

  localparam int LOW_BIT  = 0;
  localparam int GATE_BIT = 1;
  localparam int HIGH_BIT = 2;

  typedef enum logic [1:0] {
    CMD_ZERO_CROSS = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_UART       = 2'd2,
    CMD_BUTTONS    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [CHAR_W-1:0]   char_code;
    logic [CHAR_W-1:0]   tens_char;
    logic [CHAR_W-1:0]   ones_char;
    logic [LEVELS_W-1:0] button_levels;
  } in_item_t;

  typedef struct packed {
    logic [LOADS_W-1:0] load_outputs;
    logic [DELAY_W-1:0] dim_delay;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/triac_phase_dimmer_switch_controller.sv =====
// Top level: event-driven triac phase dimmer and load switch controller
// Flow: an accepted item is held in the input register, processed from there,
//   and its result is written to the result register and offered from then on.
// Throughput: one item per cycle unless out_stall holds a waiting result;
//   the input register and the result register let a new item enter while a finished result waits to be taken.
// Reset (rst_n low, synchronous): all controller state and the valid flags
//   clear, dim_step returns to 10 and gate_pulse_ticks to 4.
`default_nettype none
module triac_phase_dimmer_switch_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire tpd_pkg::in_item_t               in_item,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      tpd_pkg::out_item_t              out_item,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [tpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tpd_pkg::in_item_t               in_item_r;
  logic                            in_valid_r;
  tpd_pkg::out_item_t              out_item_r;
  logic                            out_valid_r;
  logic                            advance;

  logic [tpd_pkg::STEP_W-1:0]      dim_step_r;
  logic [tpd_pkg::PULSE_W-1:0]     gate_pulse_r;

  logic [tpd_pkg::LOADS_W-1:0]     load_bits_r,  load_bits_nxt;
  logic [tpd_pkg::DELAY_W-1:0]     delay_r,      delay_nxt;
  logic [tpd_pkg::PHASE_W-1:0]     phase_r,      phase_nxt;
  logic                            armed_r,      armed_nxt;
  logic [tpd_pkg::LEVELS_W-1:0]    held_r,       held_nxt;
  logic [3:0]                      toggle_r,     toggle_nxt;

  logic [tpd_pkg::PHASE_W-1:0]     pulse_end;
  logic [tpd_pkg::LEVELS_W-1:0]    rise;
  logic [tpd_pkg::DELAY_W:0]       up_sum;
  logic [tpd_pkg::DELAY_W-1:0]     up_delay;
  logic [tpd_pkg::DELAY_W-1:0]     down_delay;
  logic signed [tpd_pkg::SVAL_W-1:0] tens_val, ones_val, s_val;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign pulse_end = {1'b0, delay_r} + {{(tpd_pkg::PHASE_W-tpd_pkg::PULSE_W){1'b0}}, gate_pulse_r};
  assign rise      = in_item_r.button_levels & ~held_r;
  assign up_sum    = {1'b0, delay_r} + {1'b0, dim_step_r};
  assign up_delay  = rise[0] ? (up_sum[tpd_pkg::DELAY_W] ? '1 : up_sum[tpd_pkg::DELAY_W-1:0])
                             : delay_r;
  assign down_delay = !rise[1] ? up_delay :
                      (up_delay > dim_step_r) ? up_delay - dim_step_r : '0;

  assign tens_val = $signed({{(tpd_pkg::SVAL_W-tpd_pkg::CHAR_W){1'b0}}, in_item_r.tens_char})
                  - $signed({{(tpd_pkg::SVAL_W-tpd_pkg::CHAR_W){1'b0}}, tpd_pkg::CHAR_ZERO});
  assign ones_val = $signed({{(tpd_pkg::SVAL_W-tpd_pkg::CHAR_W){1'b0}}, in_item_r.ones_char})
                  - $signed({{(tpd_pkg::SVAL_W-tpd_pkg::CHAR_W){1'b0}}, tpd_pkg::CHAR_ZERO});
  assign s_val    = (tens_val <<< 3) + (tens_val <<< 1) + ones_val;

  always_comb begin
    load_bits_nxt = load_bits_r;
    delay_nxt     = delay_r;
    phase_nxt     = phase_r;
    armed_nxt     = armed_r;
    held_nxt      = held_r;
    toggle_nxt    = toggle_r;
    unique case (in_item_r.command)
      tpd_pkg::CMD_ZERO_CROSS: begin
        armed_nxt = 1'b1;
        phase_nxt = '0;
      end
      tpd_pkg::CMD_TICK: begin
        if (armed_r) begin
          if (delay_r == '0) begin
            load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b0;
          end else begin
            if (phase_r >= {1'b0, delay_r}) begin
              load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b1;
            end
            if (delay_r == tpd_pkg::DELAY_W'(1)) begin
              load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b1;
            end
            if (phase_r > pulse_end) begin
              phase_nxt = '0;
              armed_nxt = 1'b0;
              load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b0;
            end else begin
              phase_nxt = phase_r + tpd_pkg::PHASE_W'(1);
            end
          end
        end
      end
      tpd_pkg::CMD_UART: begin
        unique case (in_item_r.char_code)
          tpd_pkg::CHAR_A: load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b1;
          tpd_pkg::CHAR_B: load_bits_nxt[tpd_pkg::GATE_BIT] = 1'b0;
          tpd_pkg::CHAR_C: load_bits_nxt[tpd_pkg::HIGH_BIT] = 1'b1;
          tpd_pkg::CHAR_D: load_bits_nxt[tpd_pkg::HIGH_BIT] = 1'b0;
          tpd_pkg::CHAR_E: load_bits_nxt[tpd_pkg::LOW_BIT]  = 1'b1;
          tpd_pkg::CHAR_F: load_bits_nxt[tpd_pkg::LOW_BIT]  = 1'b0;
          tpd_pkg::CHAR_S: begin
            if (s_val < 0) begin
              delay_nxt = '0;
            end else if (s_val > $signed(tpd_pkg::SVAL_W'(255))) begin
              delay_nxt = '1;
            end else begin
              delay_nxt = s_val[tpd_pkg::DELAY_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      tpd_pkg::CMD_BUTTONS: begin
        delay_nxt = down_delay;
        if (rise[2]) begin
          toggle_nxt[0] = ~toggle_r[0];
          load_bits_nxt[tpd_pkg::GATE_BIT] = ~toggle_r[0];
        end
        if (rise[3]) begin
          toggle_nxt[1] = ~toggle_r[1];
          load_bits_nxt[tpd_pkg::HIGH_BIT] = ~toggle_r[1];
        end
        if (rise[4]) begin
          toggle_nxt[2] = ~toggle_r[2];
          load_bits_nxt[tpd_pkg::LOW_BIT] = ~toggle_r[2];
        end
        if (rise[5]) begin
          toggle_nxt[3] = ~toggle_r[3];
          delay_nxt = toggle_r[3] ? tpd_pkg::DELAY_W'(1) : '0;
        end
        held_nxt = in_item_r.button_levels;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      dim_step_r   <= tpd_pkg::DIM_STEP_RST;
      gate_pulse_r <= tpd_pkg::GATE_PULSE_RST;
      load_bits_r  <= '0;
      delay_r      <= '0;
      phase_r      <= '0;
      armed_r      <= 1'b0;
      held_r       <= '0;
      toggle_r     <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        load_bits_r <= load_bits_nxt;
        delay_r     <= delay_nxt;
        phase_r     <= phase_nxt;
        armed_r     <= armed_nxt;
        held_r      <= held_nxt;
        toggle_r    <= toggle_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tpd_pkg::REG_DIM_STEP) begin
          dim_step_r <= cfg_data[tpd_pkg::STEP_W-1:0];
        end else if (cfg_index == tpd_pkg::REG_GATE_PULSE) begin
          gate_pulse_r <= cfg_data[tpd_pkg::PULSE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r.load_outputs <= load_bits_nxt;
      out_item_r.dim_delay    <= delay_nxt;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with no held item");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item did not reach result register");

  a_cross_arms: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.command == tpd_pkg::CMD_ZERO_CROSS |=> armed_r && phase_r == '0)
    else $error("zero crossing did not arm phase counter");

  a_zero_delay_gate_off: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.command == tpd_pkg::CMD_TICK && armed_r && delay_r == '0
    |=> !load_bits_r[tpd_pkg::GATE_BIT] && !out_item_r.load_outputs[tpd_pkg::GATE_BIT])
    else $error("gate not forced off at zero delay");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_item_r.load_outputs == load_bits_r && out_item_r.dim_delay == delay_r)
    else $error("result item differs from state after item");

endmodule
`default_nettype wire
